[rtl/psc_pkg.sv]
package psc_pkg;

    localparam int LATENCY = 11;

    localparam logic [2:0] CFG_MODEL_SELECT = 3'd0;
    localparam logic [2:0] CFG_PRESS_SENS   = 3'd1;
    localparam logic [2:0] CFG_PRESS_OFFSET = 3'd2;
    localparam logic [2:0] CFG_SENS_TCO     = 3'd3;
    localparam logic [2:0] CFG_OFFSET_TCO   = 3'd4;
    localparam logic [2:0] CFG_REF_TEMP     = 3'd5;
    localparam logic [2:0] CFG_TEMP_SENS    = 3'd6;

    // temperature bands on the first-order value, centidegrees
    localparam logic signed [18:0] T_MID       = 19'sd2000;
    localparam logic signed [18:0] T_VLOW_EDGE = -19'sd1599;
    localparam logic signed [18:0] T_VLOW_OFS  = 19'sd1500;

    typedef struct packed {
        logic        two_bar;
        logic [15:0] sens;
        logic [15:0] off;
        logic [15:0] tcs;
        logic [15:0] tco;
        logic [15:0] tref;
        logic [15:0] tsens;
    } t_cal;

    typedef struct packed {
        logic        valid;
        logic [23:0] praw;
        logic [39:0] sens_lin1;
        logic [39:0] off_lin1;
        logic [34:0] sq_rel;
        logic [34:0] sq_vlow;
        logic        lt20;
        logic        ltm15;
        logic [19:0] temp;
    } t_front;

    typedef struct packed {
        logic        valid;
        logic [23:0] praw;
        logic [39:0] sens_lin;
        logic [39:0] off_lin;
        logic [19:0] temp;
    } t_lin;

endpackage

[rtl/psc_front.sv]
module psc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [23:0]     i_pressure_raw,
    input  logic [23:0]     i_temperature_raw,
    input  psc_pkg::t_cal   i_cal,
    output psc_pkg::t_front o_front
);

    // stage 1: temperature difference
    logic        r1_valid;
    logic [24:0] r1_diff;
    logic [23:0] r1_praw;
    logic [24:0] n1_diff;

    assign n1_diff = {1'b0, i_temperature_raw} - {1'b0, i_cal.tref, 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_diff <= n1_diff;
        r1_praw <= i_pressure_raw;
    end

    // stage 2: products with the difference
    logic        r2_valid;
    logic [41:0] r2_p_sens;
    logic [41:0] r2_p_off;
    logic [41:0] r2_p_temp;
    logic [47:0] r2_dsq;
    logic [23:0] r2_praw;
    logic [41:0] n2_p_sens;
    logic [41:0] n2_p_off;
    logic [41:0] n2_p_temp;
    logic [49:0] n2_dsq;

    assign n2_p_sens = $signed({1'b0, i_cal.tcs}) * $signed(r1_diff);
    assign n2_p_off  = $signed({1'b0, i_cal.tco}) * $signed(r1_diff);
    assign n2_p_temp = $signed({1'b0, i_cal.tsens}) * $signed(r1_diff);
    assign n2_dsq    = $signed(r1_diff) * $signed(r1_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_p_sens <= n2_p_sens;
        r2_p_off  <= n2_p_off;
        r2_p_temp <= n2_p_temp;
        r2_dsq    <= n2_dsq[47:0];
        r2_praw   <= r1_praw;
    end

    // stage 3: first-order terms, candidate temperature corrections
    logic        r3_valid;
    logic [39:0] r3_sens_lin1;
    logic [39:0] r3_off_lin1;
    logic [18:0] r3_t_first;
    logic [16:0] r3_tc_a;
    logic [16:0] r3_tc_b;
    logic [16:0] r3_tc_c;
    logic [23:0] r3_praw;
    logic [41:0] s_sens7;
    logic [41:0] s_sens8;
    logic [41:0] s_off6;
    logic [41:0] s_off7;
    logic [41:0] s_temp23;
    logic [51:0] m11;
    logic [49:0] m3;
    logic [39:0] n3_sens_lin1;
    logic [39:0] n3_off_lin1;
    logic [18:0] n3_t_first;

    assign s_sens7  = r2_p_sens + {35'd0, {7{r2_p_sens[41]}}};
    assign s_sens8  = r2_p_sens + {34'd0, {8{r2_p_sens[41]}}};
    assign s_off6   = r2_p_off + {36'd0, {6{r2_p_off[41]}}};
    assign s_off7   = r2_p_off + {35'd0, {7{r2_p_off[41]}}};
    assign s_temp23 = r2_p_temp + {19'd0, {23{r2_p_temp[41]}}};
    assign m11      = {1'b0, r2_dsq, 3'b000} + {3'b000, r2_dsq, 1'b0} + {4'd0, r2_dsq};
    assign m3       = {1'b0, r2_dsq, 1'b0} + {2'b00, r2_dsq};

    always_comb begin
        if (i_cal.two_bar) begin
            n3_sens_lin1 = {8'd0, i_cal.sens, 16'd0} + {{5{s_sens7[41]}}, s_sens7[41:7]};
            n3_off_lin1  = {7'd0, i_cal.off, 17'd0} + {{4{s_off6[41]}}, s_off6[41:6]};
        end else begin
            n3_sens_lin1 = {9'd0, i_cal.sens, 15'd0} + {{6{s_sens8[41]}}, s_sens8[41:8]};
            n3_off_lin1  = {8'd0, i_cal.off, 16'd0} + {{5{s_off7[41]}}, s_off7[41:7]};
        end
    end

    assign n3_t_first = s_temp23[41:23] + psc_pkg::T_MID;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_sens_lin1 <= n3_sens_lin1;
        r3_off_lin1  <= n3_off_lin1;
        r3_t_first   <= n3_t_first;
        r3_tc_a      <= m11[51:35];
        r3_tc_b      <= m3[49:33];
        r3_tc_c      <= {5'd0, r2_dsq[47:36]};
        r3_praw      <= r2_praw;
    end

    // stage 4: bands, final temperature, squares for the second order
    logic        r4_valid;
    logic [39:0] r4_sens_lin1;
    logic [39:0] r4_off_lin1;
    logic [34:0] r4_sq_rel;
    logic [34:0] r4_sq_vlow;
    logic        r4_lt20;
    logic        r4_ltm15;
    logic [19:0] r4_temp;
    logic [23:0] r4_praw;
    logic        n4_lt20;
    logic        n4_ltm15;
    logic [18:0] t_rel;
    logic [18:0] t_vlow;
    logic [37:0] n4_sq_rel;
    logic [37:0] n4_sq_vlow;
    logic [16:0] tc_sel;

    assign n4_lt20    = $signed(r3_t_first) < psc_pkg::T_MID;
    assign n4_ltm15   = $signed(r3_t_first) < psc_pkg::T_VLOW_EDGE;
    assign t_rel      = r3_t_first - psc_pkg::T_MID;
    assign t_vlow     = r3_t_first + psc_pkg::T_VLOW_OFS;
    assign n4_sq_rel  = $signed(t_rel) * $signed(t_rel);
    assign n4_sq_vlow = $signed(t_vlow) * $signed(t_vlow);

    always_comb begin
        if (i_cal.two_bar) begin
            tc_sel = n4_lt20 ? r3_tc_a : 17'd0;
        end else begin
            tc_sel = n4_lt20 ? r3_tc_b : r3_tc_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_sens_lin1 <= r3_sens_lin1;
        r4_off_lin1  <= r3_off_lin1;
        r4_sq_rel    <= n4_sq_rel[34:0];
        r4_sq_vlow   <= n4_sq_vlow[34:0];
        r4_lt20      <= n4_lt20;
        r4_ltm15     <= n4_ltm15;
        r4_temp      <= {r3_t_first[18], r3_t_first} - {3'd0, tc_sel};
        r4_praw      <= r3_praw;
    end

    assign o_front.valid     = r4_valid;
    assign o_front.praw      = r4_praw;
    assign o_front.sens_lin1 = r4_sens_lin1;
    assign o_front.off_lin1  = r4_off_lin1;
    assign o_front.sq_rel    = r4_sq_rel;
    assign o_front.sq_vlow   = r4_sq_vlow;
    assign o_front.lt20      = r4_lt20;
    assign o_front.ltm15     = r4_ltm15;
    assign o_front.temp      = r4_temp;

    a_band_nested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r4_ltm15) |-> r4_lt20)
        else $error("very-low band outside low band");

endmodule

[rtl/psc_corr.sv]
module psc_corr (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_two_bar,
    input  psc_pkg::t_front i_front,
    output psc_pkg::t_lin   o_lin
);

    // stage 1: second-order corrections
    logic        r1_valid;
    logic [38:0] r1_off_corr;
    logic [38:0] r1_sens_corr;
    logic [39:0] r1_sens_lin1;
    logic [39:0] r1_off_lin1;
    logic [19:0] r1_temp;
    logic [23:0] r1_praw;
    logic [39:0] c31;
    logic [40:0] c63;
    logic [36:0] c3;
    logic [37:0] c5;
    logic [37:0] v7;
    logic [36:0] v4;
    logic [38:0] n_off_corr;
    logic [38:0] n_sens_corr;

    assign c31 = {i_front.sq_rel, 5'd0} - {5'd0, i_front.sq_rel};
    assign c63 = {i_front.sq_rel, 6'd0} - {6'd0, i_front.sq_rel};
    assign c3  = {1'b0, i_front.sq_rel, 1'b0} + {2'd0, i_front.sq_rel};
    assign c5  = {1'b0, i_front.sq_rel, 2'd0} + {3'd0, i_front.sq_rel};
    assign v7  = {i_front.sq_vlow, 3'd0} - {3'd0, i_front.sq_vlow};
    assign v4  = {i_front.sq_vlow, 2'd0};

    always_comb begin
        n_off_corr  = 39'd0;
        n_sens_corr = 39'd0;
        if (i_two_bar) begin
            if (i_front.lt20) begin
                n_off_corr  = {2'd0, c31[39:3]};
                n_sens_corr = {3'd0, c63[40:5]};
            end
        end else if (i_front.lt20) begin
            n_off_corr  = {3'd0, c3[36:1]} + (i_front.ltm15 ? {1'b0, v7} : 39'd0);
            n_sens_corr = {4'd0, c5[37:3]} + (i_front.ltm15 ? {2'd0, v4} : 39'd0);
        end else begin
            n_off_corr  = {8'd0, i_front.sq_rel[34:4]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_front.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_off_corr  <= n_off_corr;
        r1_sens_corr <= n_sens_corr;
        r1_sens_lin1 <= i_front.sens_lin1;
        r1_off_lin1  <= i_front.off_lin1;
        r1_temp      <= i_front.temp;
        r1_praw      <= i_front.praw;
    end

    // stage 2: apply corrections
    logic        r2_valid;
    logic [39:0] r2_sens_lin;
    logic [39:0] r2_off_lin;
    logic [19:0] r2_temp;
    logic [23:0] r2_praw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sens_lin <= r1_sens_lin1 - {1'b0, r1_sens_corr};
        r2_off_lin  <= r1_off_lin1 - {1'b0, r1_off_corr};
        r2_temp     <= r1_temp;
        r2_praw     <= r1_praw;
    end

    assign o_lin.valid    = r2_valid;
    assign o_lin.praw     = r2_praw;
    assign o_lin.sens_lin = r2_sens_lin;
    assign o_lin.off_lin  = r2_off_lin;
    assign o_lin.temp     = r2_temp;

endmodule

[rtl/psc_press.sv]
module psc_press (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_two_bar,
    input  psc_pkg::t_lin i_lin,
    output logic          o_valid,
    output logic [31:0]   o_pressure_comp,
    output logic [31:0]   o_temperature_comp
);

    // stage 1: partial products of raw pressure and sensitivity
    logic        r1_valid;
    logic [43:0] r1_pp_lo;
    logic [44:0] r1_pp_hi;
    logic [39:0] r1_off_lin;
    logic [19:0] r1_temp;
    logic [43:0] n1_pp_lo;
    logic [44:0] n1_pp_hi;

    assign n1_pp_lo = {20'd0, i_lin.praw} * {24'd0, i_lin.sens_lin[19:0]};
    assign n1_pp_hi = $signed({1'b0, i_lin.praw}) * $signed(i_lin.sens_lin[39:20]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_lin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pp_lo   <= n1_pp_lo;
        r1_pp_hi   <= n1_pp_hi;
        r1_off_lin <= i_lin.off_lin;
        r1_temp    <= i_lin.temp;
    end

    // stage 2: full product
    logic        r2_valid;
    logic [63:0] r2_prod;
    logic [39:0] r2_off_lin;
    logic [19:0] r2_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_prod    <= {r1_pp_hi[43:0], 20'd0} + {20'd0, r1_pp_lo};
        r2_off_lin <= r1_off_lin;
        r2_temp    <= r1_temp;
    end

    // stage 3: scale product, truncating towards zero
    logic        r3_valid;
    logic [42:0] r3_q1;
    logic [39:0] r3_off_lin;
    logic [19:0] r3_temp;
    logic [63:0] s_prod21;

    assign s_prod21 = r2_prod + {43'd0, {21{r2_prod[63]}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_q1      <= s_prod21[63:21];
        r3_off_lin <= r2_off_lin;
        r3_temp    <= r2_temp;
    end

    // stage 4: remove offset
    logic        r4_valid;
    logic [43:0] r4_d;
    logic [19:0] r4_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_d    <= {r3_q1[42], r3_q1} - {{4{r3_off_lin[39]}}, r3_off_lin};
        r4_temp <= r3_temp;
    end

    // stage 5: final scale and output word
    logic        r5_valid;
    logic [31:0] r5_press;
    logic [31:0] r5_temp;
    logic [43:0] s_d15;
    logic [43:0] s_d13;
    logic [31:0] n5_press;

    assign s_d15 = r4_d + {29'd0, {15{r4_d[43]}}};
    assign s_d13 = r4_d + {31'd0, {13{r4_d[43]}}};

    always_comb begin
        if (i_two_bar) begin
            n5_press = {{3{s_d15[43]}}, s_d15[43:15]};
        end else begin
            n5_press = {s_d13[43], s_d13[43:13]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_press <= n5_press;
        r5_temp  <= {{12{r4_temp[19]}}, r4_temp};
    end

    assign o_valid            = r5_valid;
    assign o_pressure_comp    = r5_press;
    assign o_temperature_comp = r5_temp;

endmodule

[rtl/pressure_sensor_compensation.sv]
// Pressure sensor compensation with second-order temperature correction.
// Input: pulse start with a raw pressure and temperature conversion word;
// busy stays low, so a word is taken at every clock edge with start high.
// Output: o_valid is high for one cycle with the compensated pressure and
// temperature; there is no back-pressure, the receiver must take every word.
// One word per cycle flows through the 11-stage datapath
// (difference, products, first-order terms, bands and squares, corrections,
// correction apply, partial products, product sum, product scaling,
// offset removal, final scaling into the output register).
// Calibration: write cfg index 0 (model select, 1 = 2-bar) and 1 to 6
// (calibration words) through i_cfg_valid/o_cfg_ready; ready is always
// high. Write only while no word is in flight.
// Reset (i_rst_n low, synchronous) clears all calibration registers and
// drops every word in flight; no result is produced for them.
module pressure_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [23:0] i_pressure_raw,
    input  logic [23:0] i_temperature_raw,
    output logic        o_valid,
    output logic [31:0] o_pressure_comp,
    output logic [31:0] o_temperature_comp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    psc_pkg::t_cal   r_cal;
    psc_pkg::t_front front;
    psc_pkg::t_lin   lin;
    logic            accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                psc_pkg::CFG_MODEL_SELECT: r_cal.two_bar <= i_cfg_data[0];
                psc_pkg::CFG_PRESS_SENS:   r_cal.sens    <= i_cfg_data;
                psc_pkg::CFG_PRESS_OFFSET: r_cal.off     <= i_cfg_data;
                psc_pkg::CFG_SENS_TCO:     r_cal.tcs     <= i_cfg_data;
                psc_pkg::CFG_OFFSET_TCO:   r_cal.tco     <= i_cfg_data;
                psc_pkg::CFG_REF_TEMP:     r_cal.tref    <= i_cfg_data;
                psc_pkg::CFG_TEMP_SENS:    r_cal.tsens   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    psc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (accept),
        .i_pressure_raw    (i_pressure_raw),
        .i_temperature_raw (i_temperature_raw),
        .i_cal             (r_cal),
        .o_front           (front)
    );

    psc_corr u_corr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_two_bar (r_cal.two_bar),
        .i_front   (front),
        .o_lin     (lin)
    );

    psc_press u_press (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_two_bar          (r_cal.two_bar),
        .i_lin              (lin),
        .o_valid            (o_valid),
        .o_pressure_comp    (o_pressure_comp),
        .o_temperature_comp (o_temperature_comp)
    );

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, psc_pkg::LATENCY))
        else $error("result word without an accepted input word");

    a_word_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(psc_pkg::LATENCY) o_valid)
        else $error("accepted word produced no result");

    a_temp_sign_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_comp[31:19] == {13{o_temperature_comp[19]}}))
        else $error("temperature result outside its range");

endmodule

[tb/sv/tb_pressure_sensor_compensation.sv]
module tb_pressure_sensor_compensation;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int N_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int RANDOM_ITEMS = N_PHASES * ITEMS_PER_PHASE;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {CAL_RANDOM, CAL_MAX, CAL_ZERO, CAL_MIXED} t_cal_mode;

    typedef struct packed {
        logic [31:0] pressure;
        logic [31:0] temperature;
    } t_reading;

    class reading_scoreboard;
        psc_pkg::t_cal cal;
        t_reading expected_readings[$];
        int errors;

        function new();
            cal = '0;
            errors = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [15:0] data);
            case (idx)
                psc_pkg::CFG_MODEL_SELECT: cal.two_bar = data[0];
                psc_pkg::CFG_PRESS_SENS:   cal.sens = data;
                psc_pkg::CFG_PRESS_OFFSET: cal.off = data;
                psc_pkg::CFG_SENS_TCO:     cal.tcs = data;
                psc_pkg::CFG_OFFSET_TCO:   cal.tco = data;
                psc_pkg::CFG_REF_TEMP:     cal.tref = data;
                psc_pkg::CFG_TEMP_SENS:    cal.tsens = data;
                default: ;
            endcase
        endfunction

        function t_reading compensate(logic [23:0] p, logic [23:0] t);
            longint praw, traw, k_sens, k_off, k_tcs, k_tco, k_tref, k_tsens;
            longint diff, sens_lin, off_lin, t_first, t_rel, t_vlow;
            longint t_corr, off_corr, sens_corr, press_c, temp_c;
            t_reading r;
            praw = p;
            traw = t;
            k_sens = cal.sens;
            k_off = cal.off;
            k_tcs = cal.tcs;
            k_tco = cal.tco;
            k_tref = cal.tref;
            k_tsens = cal.tsens;
            t_corr = 0;
            off_corr = 0;
            sens_corr = 0;

            diff = traw - k_tref * 256;
            if (cal.two_bar) begin
                sens_lin = k_sens * 65536 + (k_tcs * diff) / 128;
                off_lin = k_off * 131072 + (k_tco * diff) / 64;
            end else begin
                sens_lin = k_sens * 32768 + (k_tcs * diff) / 256;
                off_lin = k_off * 65536 + (k_tco * diff) / 128;
            end

            t_first = 2000 + (diff * k_tsens) / 64'sd8388608;
            t_rel = t_first - 2000;
            t_vlow = t_first + 1500;

            if (cal.two_bar) begin
                if (t_first / 100 < 20) begin
                    t_corr = (11 * diff * diff) / 64'sd34359738368;
                    off_corr = (31 * t_rel * t_rel) / 8;
                    sens_corr = (63 * t_rel * t_rel) / 32;
                end
            end else if (t_first / 100 < 20) begin
                t_corr = (3 * diff * diff) / 64'sd8589934592;
                off_corr = (3 * t_rel * t_rel) / 2;
                sens_corr = (5 * t_rel * t_rel) / 8;
                if (t_first / 100 < -15) begin
                    off_corr += 7 * t_vlow * t_vlow;
                    sens_corr += 4 * t_vlow * t_vlow;
                end
            end else begin
                t_corr = (2 * diff * diff) / 64'sd137438953472;
                off_corr = (t_rel * t_rel) / 16;
            end

            sens_lin -= sens_corr;
            off_lin -= off_corr;
            temp_c = t_first - t_corr;
            if (cal.two_bar)
                press_c = ((praw * sens_lin) / 64'sd2097152 - off_lin) / 32768;
            else
                press_c = ((praw * sens_lin) / 64'sd2097152 - off_lin) / 8192;

            r.pressure = press_c[31:0];
            r.temperature = temp_c[31:0];
            return r;
        endfunction

        function void note_input(logic [23:0] p, logic [23:0] t);
            expected_readings.push_back(compensate(p, t));
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %0d, want %0d", what, $signed(got), $signed(want));
            errors++;
        endtask

        task check_result(logic [31:0] p, logic [31:0] t);
            t_reading want;
            if (expected_readings.size() == 0) begin
                report("reading with no input pending", p, 32'd0);
            end else begin
                want = expected_readings.pop_front();
                if (p !== want.pressure)
                    report("pressure_comp", p, want.pressure);
                if (t !== want.temperature)
                    report("temperature_comp", t, want.temperature);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [23:0] i_pressure_raw = '0;
    logic [23:0] i_temperature_raw = '0;
    logic        o_valid;
    logic [31:0] o_pressure_comp;
    logic [31:0] o_temperature_comp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int cycle_count = 0;
    reading_scoreboard board = new();

    pressure_sensor_compensation u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_pressure_raw     (i_pressure_raw),
        .i_temperature_raw  (i_temperature_raw),
        .o_valid            (o_valid),
        .o_pressure_comp    (o_pressure_comp),
        .o_temperature_comp (o_temperature_comp),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_result(o_pressure_comp, o_temperature_comp);
    end

    // start is left high; the caller drops it when a gap follows
    task automatic send_word(input logic [23:0] p, input logic [23:0] t);
        start <= 1'b1;
        i_pressure_raw <= p;
        i_temperature_raw <= t;
        do @(posedge i_clk); while (busy);
        board.note_input(p, t);
    endtask

    task automatic idle_gap(input int pct);
        int n;
        if ($urandom_range(99) < pct) begin
            n = $urandom_range(4, 1);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // valid is left high; the caller drops it after the last word
    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, data);
    endtask

    task automatic apply_cal(input psc_pkg::t_cal c);
        logic [14:0] junk;
        junk = 15'($urandom);
        write_register(psc_pkg::CFG_MODEL_SELECT, {junk, c.two_bar});
        write_register(psc_pkg::CFG_PRESS_SENS, c.sens);
        write_register(psc_pkg::CFG_PRESS_OFFSET, c.off);
        write_register(psc_pkg::CFG_SENS_TCO, c.tcs);
        write_register(psc_pkg::CFG_OFFSET_TCO, c.tco);
        write_register(psc_pkg::CFG_REF_TEMP, c.tref);
        write_register(psc_pkg::CFG_TEMP_SENS, c.tsens);
        write_register(CFG_UNUSED, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] cal_word(input t_cal_mode mode);
        case (mode)
            CAL_MAX:  return 16'hFFFF;
            CAL_ZERO: return 16'h0000;
            CAL_MIXED: begin
                case ($urandom_range(2))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    default: return 16'($urandom);
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic psc_pkg::t_cal random_cal(input int ph);
        psc_pkg::t_cal c;
        t_cal_mode mode;
        case (ph)
            0, 1: mode = CAL_RANDOM;
            2, 3: mode = CAL_MAX;
            4: mode = CAL_ZERO;
            default: mode = CAL_MIXED;
        endcase
        c.two_bar = (ph < 4) ? ph[0] : 1'($urandom);
        c.sens = cal_word(mode);
        c.off = cal_word(mode);
        c.tcs = cal_word(mode);
        c.tco = cal_word(mode);
        c.tref = cal_word(mode);
        c.tsens = cal_word(mode);
        return c;
    endfunction

    function automatic logic [23:0] pick_pressure();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        return 24'($urandom);
    endfunction

    // half of the values lie near the reference point so that every temperature band is hit
    function automatic logic [23:0] pick_temperature();
        int span;
        int v;
        case ($urandom_range(7))
            0: return $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
            1, 2, 3: return 24'($urandom);
            default: begin
                span = 1 << $urandom_range(20);
                v = int'(board.cal.tref) * 256 - span + int'($urandom_range(2 * span));
                if (v < 0)
                    v = 0;
                if (v > 24'hFFFFFF)
                    v = 24'hFFFFFF;
                return v[23:0];
            end
        endcase
    endfunction

    function automatic int sender_idle_pct(input int n);
        if (n < RANDOM_ITEMS / 3)
            return 30;
        if (n < 2 * RANDOM_ITEMS / 3)
            return 80;
        return 0;
    endfunction

    // with tref 0x8000 and tsens 8192 the first-order temperature is 2000 + diff/1024
    task automatic send_band_words();
        int band_t[8] = '{2000, 2000, 1999, -1600, -1600, -1600, -50, 4000};
        int band_n[8] = '{0, -1, 0, 1, 0, -1024, 0, 0};
        int v;
        for (int i = 0; i < 8; i++) begin
            v = 8388608 + (band_t[i] - 2000) * 1024 + band_n[i];
            send_word(i[0] ? 24'($urandom) : 24'hFFFFFF, v[23:0]);
        end
    endtask

    initial begin
        psc_pkg::t_cal c;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration
        send_word(24'h000000, 24'h000000);
        send_word(24'hFFFFFF, 24'hFFFFFF);
        drain();

        c = '{two_bar: 1'b0, sens: 16'd40000, off: 16'd35000, tcs: 16'd30000,
              tco: 16'd25000, tref: 16'h8000, tsens: 16'd8192};
        apply_cal(c);
        send_band_words();
        drain();
        c.two_bar = 1'b1;
        apply_cal(c);
        send_band_words();
        drain();

        for (int m = 0; m < 2; m++) begin
            c = '{two_bar: m[0], sens: 16'hFFFF, off: 16'hFFFF, tcs: 16'hFFFF,
                  tco: 16'hFFFF, tref: 16'hFFFF, tsens: 16'hFFFF};
            apply_cal(c);
            send_word(24'h000000, 24'h000000);
            send_word(24'hFFFFFF, 24'hFFFFFF);
            send_word(24'hFFFFFF, 24'h000000);
            send_word(24'h000000, 24'hFFFFFF);
            drain();
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            apply_cal(random_cal(ph));
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                idle_gap(sender_idle_pct(ph * ITEMS_PER_PHASE + k));
                send_word(pick_pressure(), pick_temperature());
                if (k == ITEMS_PER_PHASE / 2)
                    drain();
            end
            drain();
        end

        repeat (psc_pkg::LATENCY + 4) @(posedge i_clk);
        if (board.pending() != 0)
            board.report("readings never returned", 32'd0, board.pending());

        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_corr.sv
rtl/psc_press.sv
rtl/pressure_sensor_compensation.sv
tb/sv/tb_pressure_sensor_compensation.sv
